### design/servo_pulse_ramp_generator_assert.svh
// Assertion macros for the servo pulse ramp generator.
// No dependencies; included inside module bodies after the package import.
`ifndef SERVO_PULSE_RAMP_GENERATOR_ASSERT_SVH
`define SERVO_PULSE_RAMP_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SPRG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sprg: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SPRG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sprg: next-cycle check failed");

`endif

### design/sprg_pkg.sv
// Package for the servo pulse ramp generator: register map, reset values,
// configuration and ramp state types. No dependencies.
package sprg_pkg;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int TICK_BITS_DEFAULT = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_TICKS  = 3'd0,
        REG_CLOSED_WIDTH = 3'd1,
        REG_OPEN_WIDTH   = 3'd2,
        REG_RAMP_BASE    = 3'd3,
        REG_STEP_TICKS   = 3'd4,
        REG_RAMP_STEPS   = 3'd5
    } cfg_index_t;

    localparam logic [15:0] FRAME_TICKS_RST  = 16'd20000;
    localparam logic [15:0] CLOSED_WIDTH_RST = 16'd996;
    localparam logic [15:0] OPEN_WIDTH_RST   = 16'd2000;
    localparam logic [15:0] RAMP_BASE_RST    = 16'd995;
    localparam logic [7:0]  STEP_TICKS_RST   = 8'd5;
    localparam logic [7:0]  RAMP_STEPS_RST   = 8'd200;

    typedef struct packed {
        logic [15:0] frame_ticks;
        logic [15:0] closed_width;
        logic [15:0] open_width;
        logic [15:0] ramp_base;
        logic [7:0]  step_ticks;
        logic [7:0]  ramp_steps;
    } cfg_t;

    // Position / ramp control state; direction 1 = closing.
    typedef struct packed {
        logic       closed;
        logic       ramping;
        logic       direction;
        logic [7:0] ramp_frame;
    } ramp_state_t;

endpackage

### design/sprg_frame_ctl.sv
// Frame-start decision for the servo pulse ramp generator: ramp sequencing
// and pulse width selection. Depends on sprg_pkg.
module sprg_frame_ctl #(
    parameter int TICK_BITS = sprg_pkg::TICK_BITS_DEFAULT
) (
    input  sprg_pkg::ramp_state_t  cur_state,
    input  logic                   close_cmd,
    input  sprg_pkg::cfg_t         cfg,
    output sprg_pkg::ramp_state_t  next_state,
    output logic [TICK_BITS-1:0]   width
);
    import sprg_pkg::*;

    localparam int SUM_W = 17;
    localparam int EXT_W = (TICK_BITS > SUM_W) ? TICK_BITS : SUM_W;
    localparam logic [EXT_W-1:0] TICK_MAX = EXT_W'((64'd1 << TICK_BITS) - 64'd1);

    ramp_state_t           st;
    logic                  use_ramp;
    logic [7:0]            level;
    logic [15:0]           product;
    logic [EXT_W-1:0]      sum_ext;
    logic [EXT_W-1:0]      steady_ext;
    logic [TICK_BITS-1:0]  ramp_w;

    // Ramp end check, then sample the command when settled.
    always_comb
    begin
        st       = cur_state;
        use_ramp = 1'b1;
        if (st.ramping && (st.ramp_frame >= cfg.ramp_steps))
        begin
            st.ramping    = 1'b0;
            st.closed     = st.direction;
            st.ramp_frame = '0;
        end
        if (!st.ramping)
        begin
            if (close_cmd == st.closed)
            begin
                use_ramp = 1'b0;
            end
            else
            begin
                st.ramping    = 1'b1;
                st.direction  = close_cmd;
                st.ramp_frame = '0;
            end
        end
    end

    // Closing counts down from ramp_steps, floored at zero.
    always_comb
    begin
        if (st.direction)
            level = (st.ramp_frame <= cfg.ramp_steps) ? (cfg.ramp_steps - st.ramp_frame) : 8'd0;
        else
            level = st.ramp_frame;
    end

    assign product    = 16'(level) * 16'(cfg.step_ticks);
    assign sum_ext    = EXT_W'(17'(cfg.ramp_base) + 17'(product));
    assign ramp_w     = (sum_ext > TICK_MAX) ? TICK_MAX[TICK_BITS-1:0]
                                             : sum_ext[TICK_BITS-1:0];
    assign steady_ext = EXT_W'(st.closed ? cfg.closed_width : cfg.open_width);

    always_comb
    begin
        next_state = st;
        if (use_ramp)
        begin
            next_state.ramp_frame = st.ramp_frame + 8'd1;
            width = ramp_w;
        end
        else
        begin
            width = steady_ext[TICK_BITS-1:0];
        end
    end

endmodule

### design/servo_pulse_ramp_generator.sv
// Servo pulse generator with a ramp between two held positions (top level).
// Depends on sprg_pkg, sprg_frame_ctl and servo_pulse_ramp_generator_assert.svh.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_ready   close_request
//   out      source     out_valid / out_ready pulse_level, held_closed, in_ramp
//   cfg      sink       cfg_write (no wait)   cfg_index, cfg_data
//
// One tick is taken per clock cycle unless a result stalls; its result is
// in the output register in the next cycle. The single output register
// sets the rate: in_ready = !out_valid || out_ready, so a stalled result
// blocks new ticks until taken. Reset (rst_n low, async) restores all but
// the payload registers, position/ramp state included; no clearing pass needed.
module servo_pulse_ramp_generator #(
    parameter int TICK_BITS = sprg_pkg::TICK_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // tick input
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                close_request,
    // per-tick result
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                pulse_level,
    output logic                                held_closed,
    output logic                                in_ramp,
    // register writes
    input  logic                                cfg_write,
    input  logic [sprg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sprg_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sprg_pkg::*;

    `include "servo_pulse_ramp_generator_assert.svh"

    localparam int CMP_W = (TICK_BITS > CFG_DATA_W) ? TICK_BITS : CFG_DATA_W;
    localparam logic [CMP_W-1:0] CLOSED_RST_EXT = CMP_W'(CLOSED_WIDTH_RST);

    // Configuration registers
    cfg_t                   cfg_reg;

    // Timebase and ramp state
    logic [TICK_BITS-1:0]   position_reg;
    logic [TICK_BITS-1:0]   position_next;
    logic [TICK_BITS-1:0]   width_reg;
    logic [TICK_BITS-1:0]   width_next;
    ramp_state_t            ramp_reg;
    ramp_state_t            ramp_next;

    // Output register
    logic                   out_valid_reg;
    logic                   pulse_level_reg;
    logic                   held_closed_reg;
    logic                   in_ramp_reg;

    ramp_state_t            fs_state;
    logic [TICK_BITS-1:0]   fs_width;
    logic                   frame_start;
    logic                   tick_xfer;
    logic [TICK_BITS-1:0]   position_inc;

    assign in_ready  = !out_valid_reg || out_ready;
    assign tick_xfer = in_valid && in_ready;

    // Register writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_ticks  <= FRAME_TICKS_RST;
            cfg_reg.closed_width <= CLOSED_WIDTH_RST;
            cfg_reg.open_width   <= OPEN_WIDTH_RST;
            cfg_reg.ramp_base    <= RAMP_BASE_RST;
            cfg_reg.step_ticks   <= STEP_TICKS_RST;
            cfg_reg.ramp_steps   <= RAMP_STEPS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_FRAME_TICKS:  cfg_reg.frame_ticks  <= cfg_data;
                REG_CLOSED_WIDTH: cfg_reg.closed_width <= cfg_data;
                REG_OPEN_WIDTH:   cfg_reg.open_width   <= cfg_data;
                REG_RAMP_BASE:    cfg_reg.ramp_base    <= cfg_data;
                REG_STEP_TICKS:   cfg_reg.step_ticks   <= cfg_data[7:0];
                REG_RAMP_STEPS:   cfg_reg.ramp_steps   <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    // Width and ramp decision, used only on the first tick of a frame.
    sprg_frame_ctl #(
        .TICK_BITS (TICK_BITS)
    ) u_frame_ctl (
        .cur_state  (ramp_reg),
        .close_cmd  (close_request),
        .cfg        (cfg_reg),
        .next_state (fs_state),
        .width      (fs_width)
    );

    assign frame_start  = (position_reg == '0);
    assign width_next   = frame_start ? fs_width : width_reg;
    assign ramp_next    = frame_start ? fs_state : ramp_reg;
    assign position_inc = position_reg + 1'b1;

    // Wrap at frame_ticks; a frame length lowered below the position
    // starts a new frame on the next tick, zero acts as one tick.
    always_comb
    begin
        if (CMP_W'(position_inc) >= CMP_W'(cfg_reg.frame_ticks))
            position_next = '0;
        else
            position_next = position_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg       <= '0;
            width_reg          <= CLOSED_RST_EXT[TICK_BITS-1:0];
            ramp_reg.closed    <= 1'b1;
            ramp_reg.ramping   <= 1'b0;
            ramp_reg.direction <= 1'b0;
            ramp_reg.ramp_frame <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (tick_xfer)
            begin
                position_reg  <= position_next;
                width_reg     <= width_next;
                ramp_reg      <= ramp_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, loaded on each tick transfer.
    always_ff @(posedge clk)
    begin
        if (tick_xfer)
        begin
            pulse_level_reg <= (position_reg < width_next);
            held_closed_reg <= ramp_next.closed;
            in_ramp_reg     <= ramp_next.ramping;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pulse_level = pulse_level_reg;
    assign held_closed = held_closed_reg;
    assign in_ramp     = in_ramp_reg;

    // Settled state always keeps the ramp frame counter cleared.
    `SPRG_ASSERT_NOW(a_settled_frame_zero, clk, rst_n, !ramp_reg.ramping, ramp_reg.ramp_frame == '0)
    // A tick is never taken over a stalled result.
    `SPRG_ASSERT_NOW(a_no_overwrite, clk, rst_n, tick_xfer, !out_valid_reg || out_ready)
    // Every tick transfer leaves a result in the output register.
    `SPRG_ASSERT_NEXT(a_result_loaded, clk, rst_n, tick_xfer, out_valid_reg)
    // The held position changes only at the end of a ramp.
    `SPRG_ASSERT_NOW(a_flip_after_ramp, clk, rst_n, !$stable(ramp_reg.closed), $past(ramp_reg.ramping))

endmodule

### sim/servo_pulse_checker.sv
// Checker for the servo pulse ramp generator: tracks register writes, predicts
// each tick's result and compares every result transfer against it.
// Depends on sprg_pkg.
module servo_pulse_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic                             close_request,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic                             pulse_level,
    input  logic                             held_closed,
    input  logic                             in_ramp,
    input  logic                             cfg_write,
    input  logic [sprg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sprg_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               error_count,
    output int                               ticks_in_flight
);
    import sprg_pkg::*;

    localparam int TW = TICK_BITS_DEFAULT;
    localparam int unsigned WIDTH_MAX = 32'((64'd1 << TW) - 64'd1);

    typedef struct packed {
        logic pulse;
        logic held;
        logic ramp;
    } tick_result_t;

    tick_result_t expected_pulses[$];

    // predictor copy of the block
    cfg_t          regs;
    logic [TW-1:0] frame_pos;
    logic [TW-1:0] pulse_width;
    logic          held;
    logic          ramping;
    logic          ramp_dir;
    logic [7:0]    ramp_frame;

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    // closing ramps count their level down, opening ramps count up
    function automatic logic [TW-1:0] ramp_pulse_width();
        int unsigned level;
        int unsigned sum;
        if (ramp_dir)
            level = (ramp_frame <= regs.ramp_steps) ? regs.ramp_steps - ramp_frame : 0;
        else
            level = ramp_frame;
        sum = regs.ramp_base + level * regs.step_ticks;
        if (sum > WIDTH_MAX)
            sum = WIDTH_MAX;
        return sum[TW-1:0];
    endfunction

    function automatic tick_result_t advance_tick(input logic cmd);
        tick_result_t  r;
        logic [TW-1:0] nxt;
        if (frame_pos == '0) begin
            if (ramping && ramp_frame >= regs.ramp_steps) begin
                ramping    = 1'b0;
                held       = ramp_dir;
                ramp_frame = '0;
            end
            if (!ramping && cmd == held) begin
                pulse_width = held ? regs.closed_width : regs.open_width;
            end
            else begin
                if (!ramping) begin
                    ramping    = 1'b1;
                    ramp_dir   = cmd;
                    ramp_frame = '0;
                end
                pulse_width = ramp_pulse_width();
                ramp_frame  = ramp_frame + 8'd1;
            end
        end
        r.pulse = (frame_pos < pulse_width);
        r.held  = held;
        r.ramp  = ramping;
        nxt = frame_pos + 1'b1;
        if (nxt >= regs.frame_ticks)
            nxt = '0;
        frame_pos = nxt;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tick_result_t want;
        if (!rst_n) begin
            regs = '{frame_ticks:  FRAME_TICKS_RST,
                     closed_width: CLOSED_WIDTH_RST,
                     open_width:   OPEN_WIDTH_RST,
                     ramp_base:    RAMP_BASE_RST,
                     step_ticks:   STEP_TICKS_RST,
                     ramp_steps:   RAMP_STEPS_RST};
            frame_pos   = '0;
            pulse_width = CLOSED_WIDTH_RST;
            held        = 1'b1;
            ramping     = 1'b0;
            ramp_dir    = 1'b0;
            ramp_frame  = '0;
            expected_pulses.delete();
            error_count = 0;
            ticks_in_flight <= 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (expected_pulses.size() == 0) begin
                    report_mismatch("result transfer with no tick outstanding");
                end
                else begin
                    want = expected_pulses.pop_front();
                    if (pulse_level !== want.pulse)
                        report_mismatch($sformatf("pulse_level %b, expected %b",
                                                  pulse_level, want.pulse));
                    if (held_closed !== want.held)
                        report_mismatch($sformatf("held_closed %b, expected %b",
                                                  held_closed, want.held));
                    if (in_ramp !== want.ramp)
                        report_mismatch($sformatf("in_ramp %b, expected %b",
                                                  in_ramp, want.ramp));
                end
            end
            // a tick taken at this edge still sees the old register values
            if (in_valid && in_ready)
                expected_pulses.push_back(advance_tick(close_request));
            if (cfg_write) begin
                case (cfg_index)
                    REG_FRAME_TICKS:  regs.frame_ticks  = cfg_data;
                    REG_CLOSED_WIDTH: regs.closed_width = cfg_data;
                    REG_OPEN_WIDTH:   regs.open_width   = cfg_data;
                    REG_RAMP_BASE:    regs.ramp_base    = cfg_data;
                    REG_STEP_TICKS:   regs.step_ticks   = cfg_data[7:0];
                    REG_RAMP_STEPS:   regs.ramp_steps   = cfg_data[7:0];
                    default: ;
                endcase
            end
            ticks_in_flight <= expected_pulses.size();
        end
    end

endmodule

### sim/testbench.sv
// Top of the servo pulse ramp generator testbench: clock, reset, register
// programming, tick stimulus and verdict. Depends on sprg_pkg, the block
// and servo_pulse_checker.
module testbench;
    import sprg_pkg::*;

    // Register indexes outside the map; writes there must change nothing.
    localparam logic [CFG_INDEX_W-1:0] IDX_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] IDX_SPARE_B = 3'd7;

    localparam int RANDOM_PHASES   = 13;
    localparam int TICKS_PER_PHASE = 140;
    localparam int CYCLE_LIMIT     = 300000;

    // Receiver stall patterns, switched each time the rx_phase counter wraps.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_SKIP_FOURTH,
        RX_TRICKLE
    } rx_mode_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   in_valid      = 1'b0;
    logic                   in_ready;
    logic                   close_request = 1'b0;
    logic                   out_valid;
    logic                   out_ready     = 1'b0;
    logic                   pulse_level;
    logic                   held_closed;
    logic                   in_ramp;
    logic                   cfg_write     = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = REG_FRAME_TICKS;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    int       error_count;
    int       ticks_in_flight;
    int       cycle_count = 0;
    int       burst_left  = 0;
    logic     cmd_level   = 1'b1;
    rx_mode_t rx_mode     = RX_ALWAYS;
    logic [5:0] rx_phase  = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    servo_pulse_ramp_generator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .close_request (close_request),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pulse_level   (pulse_level),
        .held_closed   (held_closed),
        .in_ramp       (in_ramp),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    servo_pulse_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .close_request   (close_request),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pulse_level     (pulse_level),
        .held_closed     (held_closed),
        .in_ramp         (in_ramp),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .error_count     (error_count),
        .ticks_in_flight (ticks_in_flight)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: out_ready follows a pattern picked each time rx_phase wraps,
    // from never stalling to ready only when rx_phase[2:0] is zero.
    always @(posedge clk)
    begin
        rx_phase <= rx_phase + 6'd1;
        if (rx_phase == '0)
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_ALWAYS:      out_ready <= 1'b1;
            RX_COIN:        out_ready <= ($urandom_range(0, 1) == 1);
            RX_SKIP_FOURTH: out_ready <= (rx_phase[1:0] != 2'd3);
            default:        out_ready <= (rx_phase[2:0] == 3'd0);
        endcase
    end

    // One register write; cfg_write drops for a cycle between writes so it
    // never gets two updates in one step.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Writes all six registers. The 8-bit ones carry random junk above
    // their width, which the block must drop.
    task automatic program_regs(input logic [15:0] ft, input logic [15:0] cw,
                                input logic [15:0] ow, input logic [15:0] rb,
                                input logic [7:0] st, input logic [7:0] rs);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(REG_FRAME_TICKS, ft);
        write_reg(REG_CLOSED_WIDTH, cw);
        write_reg(REG_OPEN_WIDTH, ow);
        write_reg(REG_RAMP_BASE, rb);
        write_reg(REG_STEP_TICKS, {junk[15:8], st});
        write_reg(REG_RAMP_STEPS, {junk[7:0], rs});
    endtask

    // One tick transfer. The sender runs in bursts; valid drops for an idle
    // gap between bursts. About one burst in four is long, which gives
    // stretches with no idling at all.
    task automatic send_tick(input logic cmd);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 12);
        end
        in_valid      <= 1'b1;
        close_request <= cmd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic send_pattern(input logic [15:0] cmds, input int count);
        for (int i = 0; i < count; i++)
            send_tick(cmds[i]);
    endtask

    // Mostly a steady command level held for a while, so ramps run to the
    // end and the position flips; some ticks carry a random level instead.
    task automatic run_commands(input int count, input int hold_max);
        int   hold_left;
        logic cmd;
        hold_left = $urandom_range(1, hold_max);
        for (int i = 0; i < count; i++) begin
            if (hold_left == 0) begin
                cmd_level = ~cmd_level;
                hold_left = $urandom_range(1, hold_max);
            end
            hold_left--;
            cmd = ($urandom_range(0, 99) < 15) ? 1'($urandom_range(0, 1)) : cmd_level;
            send_tick(cmd);
        end
    endtask

    // Idle the tick side and wait until every result transfer is done.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ticks_in_flight != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] ft;
        logic [15:0] cw;
        logic [15:0] ow;
        logic [15:0] rb;
        logic [7:0]  st;
        logic [7:0]  rs;
        int          hold_max;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: the first tick is a frame start with an open
        // command, so an opening ramp starts in a 20000-tick frame.
        send_pattern(16'b0000_0000_0001_0110, 6);
        wait_drained();

        // Frame length cut below the current position; ramp length cut
        // to the ramp frame already reached; ramp widths saturate;
        // open width covers the whole frame.
        program_regs(16'd4, 16'd0, 16'hFFFF, 16'hFFFF, 8'd255, 8'd1);
        send_pattern(16'b0000_0011_1110_0000, 10);
        wait_drained();

        // Zero frame length acts as one tick per frame; zero ramp steps
        // gives a single level-zero ramp frame; spare indexes are ignored.
        write_reg(REG_FRAME_TICKS, 16'd0);
        write_reg(REG_RAMP_STEPS, 16'hC300);
        write_reg(REG_RAMP_BASE, 16'd0);
        write_reg(REG_STEP_TICKS, 16'h0003);
        write_reg(IDX_SPARE_A, 16'hFFFF);
        write_reg(IDX_SPARE_B, 16'h5A5A);
        send_pattern(16'b0000_0000_1001_1001, 8);
        wait_drained();

        // Random phases: short frames and ramps so positions flip often,
        // with a few extreme settings mixed in.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    ft = 16'hFFFF; cw = 16'hFFFF; ow = 16'd0;
                    rb = 16'd0;    st = 8'd255;   rs = 8'd255;
                end
                1: begin
                    ft = 16'd1; cw = 16'd0; ow = 16'd1;
                    rb = 16'hFFFF; st = 8'd1; rs = 8'd1;
                end
                default: begin
                    ft = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 2))
                                                     : 16'($urandom_range(3, 20));
                    cw = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, ft + 2));
                    ow = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, ft + 2));
                    rb = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(65280, 65535))
                                                     : 16'($urandom_range(0, ft));
                    st = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(1, 3));
                    if ($urandom_range(0, 7) == 0)
                        rs = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    else
                        rs = 8'($urandom_range(1, 6));
                end
            endcase
            program_regs(ft, cw, ow, rb, st, rs);
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? IDX_SPARE_A : IDX_SPARE_B, 16'($urandom));

            // hold a command about two ramps long, within reason
            hold_max = (rs + 2) * (ft + 1) * 2;
            if (hold_max > 150)
                hold_max = 150;
            run_commands(TICKS_PER_PHASE, hold_max);
            wait_drained();
        end

        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
